@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the blocker's checkers. Each expands to one
// labeled concurrent assertion clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define CBC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbc checker: same-cycle rule violated");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbc checker: next-cycle rule violated");

`endif

@@ design/cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the card blank-compression record blocker.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Default geometry
  localparam int CARD_BYTES_DEF  = 80;
  localparam int BLOCK_BYTES_DEF = 512;

  // Byte values
  localparam logic [7:0] MARKER_RESET = 8'h1F;
  localparam logic [7:0] BLANK_BYTE   = 8'h20;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] LOWER_Z      = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // One input beat: a raw card byte
  typedef struct packed {
    logic [7:0] card_byte;
    logic       job_end;
  } cbc_in_t;

  // One output beat: a block write of up to eight bytes
  typedef struct packed {
    logic [15:0] block_number;
    logic [8:0]  byte_offset;
    logic [63:0] write_data;
    logic [3:0]  byte_count;
    logic        new_block;
    logic        job_done;
    logic        last;
  } cbc_out_t;

endpackage

@@ design/card_blank_compress_blocker.sv @@
// ----------------------------------------------------------------------------
// card_blank_compress_blocker
// Upper-cases card bytes, folds blank runs into marker/count pairs, buffers
// each compressed record in a two-bank word RAM and emits it at card end as
// a length byte plus record, in block writes of up to eight bytes.
//
//   channel  signals                          direction  per beat
//   card     card_valid card_ready card       in         one raw card byte
//   blk      blk_valid blk_ready blk_beat     out        one block write
//   marker   marker_we marker_data            in         marker register
//
// One card byte is taken per cycle. Record bytes are packed into an 8-byte
// staging word that is written to RAM when full, one word per cycle.
// Emission reads one RAM word per beat but the last, which takes the staged
// tail word, and overlaps the next card through the second RAM bank.
// The byte that ends a card waits while the previous card is still emitting.
// rst (synchronous) clears all control state; the marker returns to 0x1F.
// ----------------------------------------------------------------------------
module card_blank_compress_blocker
  import cbc_pkg::*;
#(
  parameter int CARD_BYTES  = CARD_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       card_valid,
  output logic       card_ready,
  input  cbc_in_t    card,
  output logic       blk_valid,
  input  logic       blk_ready,
  output cbc_out_t   blk_beat,
  input  logic       marker_we,
  input  logic [7:0] marker_data
);

  localparam int PW        = $clog2(CARD_BYTES);
  localparam int RW        = $clog2(CARD_BYTES + 1);
  localparam int AW        = $clog2(CARD_BYTES / 8 + 1);
  localparam int LW        = AW + 3;
  localparam int FW        = $clog2(BLOCK_BYTES + 1);
  localparam int RAM_DEPTH = 2 ** (AW + 1);

  localparam logic [PW-1:0] LAST_POS = PW'(CARD_BYTES - 1);

  // Emitter states
  localparam logic [1:0] EM_IDLE = 2'd0;
  localparam logic [1:0] EM_READ = 2'd1;
  localparam logic [1:0] EM_DATA = 2'd2;

  // Intake state
  logic [7:0]    marker;
  logic [PW-1:0] pos;
  logic [RW-1:0] run;
  logic [7:0]    stage [8];
  logic [2:0]    fill;
  logic [AW-1:0] waddr;
  logic          bank;
  logic [FW-1:0] fill_offset;
  logic [15:0]   cur_block;
  logic          opened;

  // Intake datapath
  logic          accept;
  logic          card_end;
  logic [7:0]    ub;
  logic          is_blank;
  logic [RW-1:0] run_inc;
  logic [RW-1:0] cl_run;
  logic [7:0]    app [3];
  logic [1:0]    app_n;
  logic [7:0]    win [16];
  logic [3:0]    new_fill;
  logic          wr_full;
  logic [7:0]    stage_next [8];
  logic [2:0]    fill_next;
  logic [AW-1:0] waddr_next;
  logic [63:0]   wr_word;
  logic [63:0]   tail_word;
  logic [LW-1:0] len_end;
  logic [LW:0]   total;
  logic [FW:0]   sum;
  logic          advance;
  logic [FW-1:0] start_off;
  logic [15:0]   block_next;

  // Emitter state
  logic [1:0]    em_state;
  logic [AW-1:0] em_j;
  logic [AW-1:0] em_last;
  logic          em_bank;
  logic [7:0]    em_len;
  logic [63:0]   em_tail;
  logic [7:0]    em_prev;
  logic [LW:0]   em_left;
  logic [8:0]    em_off;
  logic [15:0]   em_block;
  logic          em_open;
  logic          em_job;

  // Emitter datapath
  logic [63:0]   ram_rd;
  logic [63:0]   word;
  logic [7:0]    bb [8];
  logic [3:0]    cnt;
  logic [63:0]   beat_data;
  logic          load;
  logic          last_beat;
  logic          rd_en;
  logic [AW:0]   rd_addr;

  // Hold the last byte of a card while the previous record is still going out
  assign card_end   = (pos == LAST_POS);
  assign card_ready = !(card_end && (em_state != EM_IDLE));
  assign accept     = card_valid && card_ready;

  // Upper-case and classify
  always_comb begin
    ub = card.card_byte;
    if (card.card_byte inside {[LOWER_A:LOWER_Z]}) begin
      ub = card.card_byte - CASE_OFFSET;
    end
    is_blank = (ub == BLANK_BYTE);
    run_inc  = run + RW'(1);
  end

  // Bytes this beat appends: a closed run, then the byte itself
  always_comb begin
    cl_run = is_blank ? run_inc : run;
    app[0] = 8'h00;
    app[1] = 8'h00;
    app[2] = 8'h00;
    app_n  = 2'd0;
    if (!is_blank || card_end) begin
      if (cl_run == RW'(1)) begin
        app[0] = BLANK_BYTE;
        app_n  = 2'd1;
      end else if (cl_run > RW'(1)) begin
        app[0] = marker;
        app[1] = 8'(cl_run);
        app_n  = 2'd2;
      end
      if (!is_blank) begin
        app[app_n] = ub;
        app_n      = app_n + 2'd1;
      end
    end
  end

  // Merge appended bytes behind the staged ones
  always_comb begin
    logic [3:0] d;
    for (int p = 0; p < 16; p++) begin
      d      = 4'(p) - {1'b0, fill};
      win[p] = 8'h00;
      if (p < 8 && 4'(p) < {1'b0, fill}) begin
        win[p] = stage[p % 8];
      end else if (d < {2'b00, app_n}) begin
        win[p] = app[d[1:0]];
      end
    end
    new_fill  = {1'b0, fill} + {2'b00, app_n};
    wr_full   = new_fill[3];
    fill_next = new_fill[2:0];
    for (int p = 0; p < 8; p++) begin
      stage_next[p]     = wr_full ? win[p + 8] : win[p];
      wr_word[8*p +: 8] = win[p];
      tail_word[8*p +: 8] = stage_next[p];
    end
    waddr_next = waddr + AW'(wr_full);
  end

  // Placement of the finished record in the block
  always_comb begin
    len_end    = {waddr_next, fill_next};
    total      = (LW+1)'(len_end) + (LW+1)'(1);
    sum        = (FW+1)'(fill_offset) + (FW+1)'(total);
    advance    = opened && (sum > (FW+1)'(BLOCK_BYTES));
    start_off  = advance ? '0 : fill_offset;
    block_next = advance ? cur_block + 16'd1 : cur_block;
  end

  // Marker register
  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MARKER_RESET;
    end else if (marker_we) begin
      marker <= marker_data;
    end
  end

  // Intake control: position, run, staging and block placement
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      run         <= '0;
      fill        <= '0;
      waddr       <= '0;
      bank        <= 1'b0;
      fill_offset <= '0;
      cur_block   <= '0;
      opened      <= 1'b0;
    end else if (accept) begin
      if (card_end) begin
        pos   <= '0;
        run   <= '0;
        fill  <= '0;
        waddr <= '0;
        bank  <= ~bank;
        if (card.job_end) begin
          fill_offset <= '0;
          cur_block   <= '0;
          opened      <= 1'b0;
        end else begin
          fill_offset <= FW'(sum - (FW+1)'(fill_offset) + (FW+1)'(start_off));
          cur_block   <= block_next;
          opened      <= 1'b1;
        end
      end else begin
        pos   <= pos + PW'(1);
        run   <= is_blank ? run_inc : '0;
        fill  <= fill_next;
        waddr <= waddr_next;
      end
    end
  end

  // Staging word contents
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int p = 0; p < 8; p++) begin
        stage[p] <= stage_next[p];
      end
    end
  end

  // Record store: two banks of staged words
  cbc_ram #(
    .WIDTH (64),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_full),
    .wr_addr ({bank, waddr}),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // Assemble the beat: previous word's top byte (or length) plus seven bytes
  always_comb begin
    last_beat = (em_j == em_last);
    word      = last_beat ? em_tail : ram_rd;
    bb[0]     = (em_j == '0) ? em_len : em_prev;
    for (int k = 1; k < 8; k++) begin
      bb[k] = word[8*(k-1) +: 8];
    end
    cnt = (em_left > (LW+1)'(8)) ? 4'd8 : 4'(em_left);
    for (int k = 0; k < 8; k++) begin
      beat_data[8*k +: 8] = (4'(k) < cnt) ? bb[k] : 8'h00;
    end
    load    = (em_state == EM_DATA) && (!blk_valid || blk_ready);
    rd_en   = (em_state == EM_READ) || (load && !last_beat);
    rd_addr = {em_bank, (em_state == EM_READ) ? em_j : em_j + AW'(1)};
  end

  // Emitter sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      em_state <= EM_IDLE;
    end else begin
      case (em_state)
        EM_IDLE: begin
          if (accept && card_end) begin
            em_state <= EM_READ;
          end
        end
        EM_READ: begin
          em_state <= EM_DATA;
        end
        EM_DATA: begin
          if (load && last_beat) begin
            em_state <= EM_IDLE;
          end
        end
        default: begin
          em_state <= EM_IDLE;
        end
      endcase
    end
  end

  // Capture the finished record's description; advance per beat
  always_ff @(posedge clk) begin
    if (accept && card_end) begin
      em_j     <= '0;
      em_last  <= waddr_next;
      em_bank  <= bank;
      em_len   <= 8'(len_end);
      em_tail  <= tail_word;
      em_left  <= total;
      em_off   <= 9'(start_off);
      em_block <= block_next;
      em_open  <= !opened || advance;
      em_job   <= card.job_end;
    end else if (load) begin
      em_j    <= em_j + AW'(1);
      em_prev <= word[63:56];
      em_left <= em_left - (LW+1)'(8);
      em_off  <= em_off + 9'd8;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (load) begin
      blk_valid <= 1'b1;
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blk_beat.block_number <= em_block;
      blk_beat.byte_offset  <= em_off;
      blk_beat.write_data   <= beat_data;
      blk_beat.byte_count   <= cnt;
      blk_beat.new_block    <= em_open && (em_j == '0);
      blk_beat.job_done     <= em_job && last_beat;
      blk_beat.last         <= last_beat;
    end
  end

endmodule

@@ design/cbc_ram.sv @@
// ----------------------------------------------------------------------------
// cbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while rd_en is low.
// ----------------------------------------------------------------------------
module cbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/cbc_check.sv @@
// ----------------------------------------------------------------------------
// cbc_check
// Port-level checker for the blocker's write stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbc_check
  import cbc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     blk_valid,
  input logic     blk_ready,
  input cbc_out_t blk_beat
);

  // Stalled write holds
  `CBC_ASSERT_NEXT(a_hold, blk_valid && !blk_ready, blk_valid && $stable(blk_beat))

  // Every write carries one to eight bytes
  `CBC_ASSERT_IMPLY(a_count, blk_valid, (blk_beat.byte_count >= 4'd1) && (blk_beat.byte_count <= 4'd8))

  // Only a card's final write may be short
  `CBC_ASSERT_IMPLY(a_full, blk_valid && !blk_beat.last, blk_beat.byte_count == 4'd8)

  // Job end comes on a card's final write
  `CBC_ASSERT_IMPLY(a_done, blk_valid && blk_beat.job_done, blk_beat.last)

  // A write that opens a block starts at its beginning
  `CBC_ASSERT_IMPLY(a_open, blk_valid && blk_beat.new_block, blk_beat.byte_offset == 9'd0)

endmodule

bind card_blank_compress_blocker cbc_check u_check (.*);
